// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/svpwm_pkg.sv -----
// Shared constants, types and tables of the SVPWM duty generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package svpwm_pkg;

	localparam int ANGLE_BITS         = 16;
	localparam int VALUE_BITS         = 16;
	localparam int SINE_TABLE_ENTRIES = 256;

	localparam int QUARTER_BITS  = ANGLE_BITS - 2;
	localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_ENTRIES);
	localparam int DUTY_BITS     = VALUE_BITS - 1;
	localparam int SECTOR_BITS   = 3;
	localparam int TRIG_BITS     = 32;   // signed Q30, holds +/-1.0

	// stream payload widths; fields fill whole bytes already
	localparam int IN_DATA_BITS  = ANGLE_BITS + 3 * VALUE_BITS;
	localparam int OUT_DATA_BITS = 3 * DUTY_BITS + SECTOR_BITS;

	localparam int UNIT = 1 << (VALUE_BITS - 2);
	localparam logic signed [VALUE_BITS-1:0] UNIT_V = VALUE_BITS'(UNIT);

	localparam logic signed [TRIG_BITS-1:0] Q30_ONE    = 32'sd1073741824;
	localparam logic signed [TRIG_BITS-1:0] Q30_HALF   = 32'sd536870912;
	localparam logic signed [TRIG_BITS-1:0] HALF_SQRT3 = 32'sd929887697;
	localparam logic [30:0]                 SQRT3_Q30  = 31'd1859775393;
	localparam longint unsigned             PI_Q30     = 64'd3373259426;

	typedef enum logic {
		OP_DQ    = 1'b0,
		OP_POLAR = 1'b1
	} opcode_t;

	typedef logic [30:0] sine_point_t;
	typedef sine_point_t sine_tab_t [0:SINE_TABLE_ENTRIES];

	// quarter-wave sine, Q30, by truncated Taylor series up to x^17
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
			x = (64'(k) * PI_Q30) / 64'(2 * SINE_TABLE_ENTRIES);
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n[0]) begin
					sum -= longint'(term);
				end else begin
					sum += longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > 64'sd1073741824) begin
				sum = 64'sd1073741824;
			end
			tab[k] = 31'(sum);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	// sin(k * 60 deg), Q30
	function automatic logic signed [TRIG_BITS-1:0] sin60(input logic [2:0] k);
		logic signed [TRIG_BITS-1:0] v;
		unique case (k)
			3'd1, 3'd2: v = HALF_SQRT3;
			3'd4, 3'd5: v = -HALF_SQRT3;
			default:    v = '0;
		endcase
		return v;
	endfunction

	// cos(k * 60 deg), Q30
	function automatic logic signed [TRIG_BITS-1:0] cos60(input logic [2:0] k);
		logic signed [TRIG_BITS-1:0] v;
		unique case (k)
			3'd1, 3'd5: v = Q30_HALF;
			3'd2, 3'd4: v = -Q30_HALF;
			3'd3:       v = -Q30_ONE;
			default:    v = Q30_ONE;   // zero and full turn
		endcase
		return v;
	endfunction

	// {beta > 0, |beta| > sqrt3*|alpha|, alpha > 0} -> sector
	function automatic logic [SECTOR_BITS-1:0] sector_of_code(input logic [2:0] code);
		logic [SECTOR_BITS-1:0] s;
		unique case (code)
			3'd0:       s = 3'd4;
			3'd1:       s = 3'd6;
			3'd2, 3'd3: s = 3'd5;
			3'd4:       s = 3'd3;
			3'd5:       s = 3'd1;
			default:    s = 3'd2;
		endcase
		return s;
	endfunction

	// switch pattern {W, V, U} of active vector V(k+1)
	function automatic logic [2:0] active_vec(input logic [2:0] k);
		logic [2:0] m;
		unique case (k)
			3'd0:    m = 3'b001;
			3'd1:    m = 3'b011;
			3'd2:    m = 3'b010;
			3'd3:    m = 3'b110;
			3'd4:    m = 3'b100;
			3'd5:    m = 3'b101;
			default: m = 3'b000;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/svpwm_sine.sv -----
// Quarter-wave table sine lookup, no interpolation, signed Q30 result.
// Depends on svpwm_pkg for the table and widths.
`default_nettype none

module svpwm_sine import svpwm_pkg::*; (
	input  logic        [ANGLE_BITS-1:0] phase,
	output logic signed [TRIG_BITS-1:0]  value
);

	logic [1:0]               quad;
	logic [SINE_IDX_BITS:0]   idx_fwd;
	logic [SINE_IDX_BITS:0]   idx_rev;
	logic [SINE_IDX_BITS:0]   idx;
	sine_point_t              point;
	logic signed [TRIG_BITS-1:0] mag;

	assign quad    = phase[ANGLE_BITS-1 -: 2];
	// floor(r * N / quarter) with N a power of two is the top index bits of r
	assign idx_fwd = {1'b0, phase[QUARTER_BITS-1 -: SINE_IDX_BITS]};
	assign idx_rev = (SINE_IDX_BITS + 1)'(SINE_TABLE_ENTRIES) - idx_fwd;
	assign idx     = quad[0] ? idx_rev : idx_fwd;
	assign point   = SINE_TAB[idx];
	assign mag     = signed'(TRIG_BITS'(point));
	assign value   = quad[1] ? -mag : mag;

endmodule

`default_nettype wire

// ----- rtl/svpwm_duty_generator.sv -----
// Top level of the seven-segment SVPWM duty generator.
// Depends on svpwm_pkg and svpwm_sine.
//
// Usage:
//   s_axis carries one request per transfer: tuser is the opcode (0 = d/q
//   voltages rotated by the electrical angle, 1 = polar angle and amplitude);
//   tdata holds angle, d_voltage, q_voltage and amplitude.
//   m_axis returns one result per request, in order: three phase duties
//   (16384 = 100 percent) and the sector number 1..6.
//   Throughput is one request per cycle while the receiver does not stall;
//   seven register stages (sine lookup, inverse Park products, alpha/beta,
//   sector test product, sector pick, dwell products, dwell times) feed an
//   output register.
//   A two-entry output buffer (output register plus skid register) keeps
//   the input ready for one more transfer after the receiver stalls; the
//   pipeline then holds and s_axis_tready drops until the stall clears.
//   Nothing is lost or repeated across stalls.
//   arst_n clears all valid bits; the block is ready right after reset.
`default_nettype none

module svpwm_duty_generator import svpwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// angle, d_voltage, q_voltage, amplitude
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// opcode
	input  logic [0:0]               s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// duty_u, duty_v, duty_w, sector
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

	localparam int PROD_BITS  = VALUE_BITS + TRIG_BITS;
	localparam int ALPHA_BITS = PROD_BITS + 1 - 30;
	localparam int CMP_BITS   = ALPHA_BITS + 31;
	localparam int TPROD_BITS = ALPHA_BITS + TRIG_BITS;
	localparam int DWELL_BITS = TPROD_BITS + 1 - 30;
	localparam int T0_BITS    = DWELL_BITS + 2;

	typedef struct packed {
		opcode_t                       op;
		logic signed [VALUE_BITS-1:0]  x;
		logic signed [VALUE_BITS-1:0]  y;
		logic signed [TRIG_BITS-1:0]   sin;
		logic signed [TRIG_BITS-1:0]   cos;
		logic [SECTOR_BITS-1:0]        psec;
	} st1_t;

	typedef struct packed {
		opcode_t                      op;
		logic signed [PROD_BITS-1:0]  xc;
		logic signed [PROD_BITS-1:0]  ys;
		logic signed [PROD_BITS-1:0]  xs;
		logic signed [PROD_BITS-1:0]  yc;
		logic [SECTOR_BITS-1:0]       psec;
	} st2_t;

	typedef struct packed {
		opcode_t                       op;
		logic signed [ALPHA_BITS-1:0]  alpha;
		logic signed [ALPHA_BITS-1:0]  beta;
		logic [SECTOR_BITS-1:0]        psec;
	} st3_t;

	typedef struct packed {
		opcode_t                       op;
		logic signed [ALPHA_BITS-1:0]  alpha;
		logic signed [ALPHA_BITS-1:0]  beta;
		logic [SECTOR_BITS-1:0]        psec;
		logic [ALPHA_BITS-1:0]         abs_beta;
		logic [CMP_BITS-1:0]           sq_alpha;
	} st4_t;

	typedef struct packed {
		logic signed [ALPHA_BITS-1:0]  alpha;
		logic signed [ALPHA_BITS-1:0]  beta;
		logic [SECTOR_BITS-1:0]        sector;
	} st5_t;

	typedef struct packed {
		logic signed [TPROD_BITS-1:0]  pm1;
		logic signed [TPROD_BITS-1:0]  pm2;
		logic signed [TPROD_BITS-1:0]  pn1;
		logic signed [TPROD_BITS-1:0]  pn2;
		logic [SECTOR_BITS-1:0]        sector;
	} st6_t;

	typedef struct packed {
		logic [DWELL_BITS-2:0]   tm;
		logic [DWELL_BITS-2:0]   tn;
		logic [T0_BITS-2:0]      t0;
		logic [SECTOR_BITS-1:0]  sector;
	} st7_t;

	logic pipe_en;
	logic take;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	st1_t st_s1;
	st2_t st_s2;
	st3_t st_s3;
	st4_t st_s4;
	st5_t st_s5;
	st6_t st_s6;
	st7_t st_s7;

	logic out_vld_q, sk_vld_q;
	logic [OUT_DATA_BITS-1:0] out_q, sk_q;

	// input unpack
	opcode_t                       in_op;
	logic [ANGLE_BITS-1:0]         in_angle;
	logic signed [VALUE_BITS-1:0]  in_d, in_q, in_amp;

	assign in_op    = opcode_t'(s_axis_tuser[0]);
	assign in_angle = s_axis_tdata[ANGLE_BITS-1:0];
	assign in_d     = signed'(s_axis_tdata[ANGLE_BITS +: VALUE_BITS]);
	assign in_q     = signed'(s_axis_tdata[ANGLE_BITS + VALUE_BITS +: VALUE_BITS]);
	assign in_amp   = signed'(s_axis_tdata[ANGLE_BITS + 2 * VALUE_BITS +: VALUE_BITS]);

	assign pipe_en       = !sk_vld_q;
	assign s_axis_tready = pipe_en;
	assign take          = s_axis_tvalid && s_axis_tready;

	// ---- stage 1: sine/cosine lookup, operand select, polar sector
	logic signed [TRIG_BITS-1:0]  sin_v, cos_v;
	logic signed [VALUE_BITS-1:0] amp_clamped;
	logic [ANGLE_BITS+2:0]        angle_x6;
	st1_t                         nx1;

	svpwm_sine u_sin (
		.phase (in_angle),
		.value (sin_v)
	);

	svpwm_sine u_cos (
		.phase (in_angle + ANGLE_BITS'(1 << QUARTER_BITS)),
		.value (cos_v)
	);

	always_comb begin
		if (in_amp < 0) begin
			amp_clamped = '0;
		end else if (in_amp > UNIT_V) begin
			amp_clamped = UNIT_V;
		end else begin
			amp_clamped = in_amp;
		end
		angle_x6 = {1'b0, in_angle, 2'b00} + {2'b00, in_angle, 1'b0};
		nx1.op   = in_op;
		nx1.sin  = sin_v;
		nx1.cos  = cos_v;
		nx1.psec = angle_x6[ANGLE_BITS+2 -: SECTOR_BITS] + SECTOR_BITS'(1);
		// polar mode reuses the rotation with y = 0
		if (in_op == OP_POLAR) begin
			nx1.x = amp_clamped;
			nx1.y = '0;
		end else begin
			nx1.x = in_d;
			nx1.y = in_q;
		end
	end

	// ---- stage 2: inverse Park products
	st2_t nx2;

	always_comb begin
		nx2.op   = st_s1.op;
		nx2.psec = st_s1.psec;
		nx2.xc   = PROD_BITS'(st_s1.x) * PROD_BITS'(st_s1.cos);
		nx2.ys   = PROD_BITS'(st_s1.y) * PROD_BITS'(st_s1.sin);
		nx2.xs   = PROD_BITS'(st_s1.x) * PROD_BITS'(st_s1.sin);
		nx2.yc   = PROD_BITS'(st_s1.y) * PROD_BITS'(st_s1.cos);
	end

	// ---- stage 3: alpha/beta, floored to value units
	st3_t nx3;
	logic signed [PROD_BITS:0] alpha_sum, beta_sum;

	always_comb begin
		alpha_sum = (PROD_BITS + 1)'(st_s2.xc) - (PROD_BITS + 1)'(st_s2.ys);
		beta_sum  = (PROD_BITS + 1)'(st_s2.xs) + (PROD_BITS + 1)'(st_s2.yc);
		nx3.op    = st_s2.op;
		nx3.psec  = st_s2.psec;
		nx3.alpha = ALPHA_BITS'(alpha_sum >>> 30);
		nx3.beta  = ALPHA_BITS'(beta_sum >>> 30);
	end

	// ---- stage 4: sqrt3*|alpha| for the sector test
	st4_t nx4;
	logic [ALPHA_BITS-1:0] abs_alpha;

	always_comb begin
		abs_alpha    = st_s3.alpha < 0 ? ALPHA_BITS'(-st_s3.alpha) : ALPHA_BITS'(st_s3.alpha);
		nx4.op       = st_s3.op;
		nx4.alpha    = st_s3.alpha;
		nx4.beta     = st_s3.beta;
		nx4.psec     = st_s3.psec;
		nx4.abs_beta = st_s3.beta < 0 ? ALPHA_BITS'(-st_s3.beta) : ALPHA_BITS'(st_s3.beta);
		nx4.sq_alpha = CMP_BITS'(SQRT3_Q30) * CMP_BITS'(abs_alpha);
	end

	// ---- stage 5: sector pick
	st5_t nx5;
	logic [2:0] sec_code;
	logic       steep;

	always_comb begin
		steep     = CMP_BITS'({st_s4.abs_beta, 30'b0}) > st_s4.sq_alpha;
		sec_code  = {st_s4.beta > 0, steep, st_s4.alpha > 0};
		nx5.alpha = st_s4.alpha;
		nx5.beta  = st_s4.beta;
		nx5.sector = (st_s4.op == OP_POLAR) ? st_s4.psec : sector_of_code(sec_code);
	end

	// ---- stage 6: dwell projections on the two active vectors
	st6_t nx6;
	logic [SECTOR_BITS-1:0] sec_prev;

	always_comb begin
		sec_prev   = st_s5.sector - SECTOR_BITS'(1);
		nx6.sector = st_s5.sector;
		nx6.pm1 = TPROD_BITS'(st_s5.alpha) * TPROD_BITS'(sin60(st_s5.sector));
		nx6.pm2 = TPROD_BITS'(st_s5.beta) * TPROD_BITS'(cos60(st_s5.sector));
		nx6.pn1 = TPROD_BITS'(st_s5.beta) * TPROD_BITS'(cos60(sec_prev));
		nx6.pn2 = TPROD_BITS'(st_s5.alpha) * TPROD_BITS'(sin60(sec_prev));
	end

	// ---- stage 7: dwell and zero times, floored at zero
	st7_t nx7;
	logic signed [DWELL_BITS-1:0] tm_raw, tn_raw;
	logic signed [T0_BITS-1:0]    t0_raw;

	always_comb begin
		tm_raw = DWELL_BITS'(((TPROD_BITS + 1)'(st_s6.pm1) - (TPROD_BITS + 1)'(st_s6.pm2)) >>> 30);
		tn_raw = DWELL_BITS'(((TPROD_BITS + 1)'(st_s6.pn1) - (TPROD_BITS + 1)'(st_s6.pn2)) >>> 30);
		// zero time uses the dwell times before their floor
		t0_raw = T0_BITS'(UNIT) - T0_BITS'(tm_raw) - T0_BITS'(tn_raw);
		nx7.tm = tm_raw < 0 ? '0 : (DWELL_BITS - 1)'(tm_raw);
		nx7.tn = tn_raw < 0 ? '0 : (DWELL_BITS - 1)'(tn_raw);
		nx7.t0 = t0_raw < 0 ? '0 : (T0_BITS - 1)'(t0_raw);
		nx7.sector = st_s6.sector;
	end

	// ---- duty sums, saturated
	logic [2:0]                 mask_m, mask_n;
	logic [SECTOR_BITS-1:0]     sec_next;
	logic [T0_BITS-1:0]         duty_sum [3];
	logic [DUTY_BITS-1:0]       duty [3];
	logic [OUT_DATA_BITS-1:0]   res_data;

	always_comb begin
		sec_next = (st_s7.sector == SECTOR_BITS'(6)) ? '0 : st_s7.sector;
		mask_m   = active_vec(st_s7.sector - SECTOR_BITS'(1));
		mask_n   = active_vec(sec_next);
		for (int ph = 0; ph < 3; ph++) begin
			duty_sum[ph] = T0_BITS'(st_s7.t0 >> 1)
				+ (mask_m[ph] ? T0_BITS'(st_s7.tm) : '0)
				+ (mask_n[ph] ? T0_BITS'(st_s7.tn) : '0);
			duty[ph] = (duty_sum[ph] > T0_BITS'(UNIT)) ? DUTY_BITS'(UNIT)
				: duty_sum[ph][DUTY_BITS-1:0];
		end
		res_data = {st_s7.sector, duty[2], duty[1], duty[0]};
	end

	// ---- pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// ---- pipeline payload
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			st_s1 <= nx1;
			st_s2 <= nx2;
			st_s3 <= nx3;
			st_s4 <= nx4;
			st_s5 <= nx5;
			st_s6 <= nx6;
			st_s7 <= nx7;
		end
	end

	// ---- output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else if (m_axis_tready || !out_vld_q) begin
			if (sk_vld_q) begin
				out_vld_q <= 1'b1;
				sk_vld_q  <= 1'b0;
			end else begin
				out_vld_q <= vld_s7;
			end
		end else if (vld_s7 && pipe_en) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_vld_q) begin
			out_q <= sk_vld_q ? sk_q : res_data;
		end else if (vld_s7 && pipe_en) begin
			sk_q <= res_data;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ----- rtl/svpwm_sva.sv -----
// Port-level checker for the SVPWM duty generator, and its bind.
// Depends on svpwm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module svpwm_sva import svpwm_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_axis_tready,
	input wire logic                     m_axis_tvalid,
	input wire logic                     m_axis_tready,
	input wire logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

	logic [SECTOR_BITS-1:0] sector;
	logic [DUTY_BITS-1:0]   duty_u, duty_v, duty_w;

	assign duty_u = m_axis_tdata[DUTY_BITS-1:0];
	assign duty_v = m_axis_tdata[2*DUTY_BITS-1 -: DUTY_BITS];
	assign duty_w = m_axis_tdata[3*DUTY_BITS-1 -: DUTY_BITS];
	assign sector = m_axis_tdata[OUT_DATA_BITS-1 -: SECTOR_BITS];

	`ASSERT_IMPLY(a_sector_range, clk, arst_n, m_axis_tvalid, (sector >= 3'd1 && sector <= 3'd6), "sector outside 1..6")

	`ASSERT_IMPLY(a_duty_sat, clk, arst_n, m_axis_tvalid, (duty_u <= DUTY_BITS'(UNIT) && duty_v <= DUTY_BITS'(UNIT) && duty_w <= DUTY_BITS'(UNIT)), "duty above full scale")

	// input side only blocks while a result is held back by the receiver
	`ASSERT_IMPLY(a_block_needs_stall, clk, arst_n, !s_axis_tready, (m_axis_tvalid && !$past(m_axis_tready)), "input blocked without output stall")

	`ASSERT_IMPLY(a_ready_after_take, clk, arst_n, $past(m_axis_tready), s_axis_tready, "input blocked after output transfer")

	`ASSERT_NEXT(a_out_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind svpwm_duty_generator svpwm_sva u_svpwm_sva (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- sim/svpwm_duty_checker.sv -----
// Stream monitor and duty-cycle predictor for the SVPWM duty generator.
// Depends on svpwm_pkg; watches both stream channels and counts mismatches.
`default_nettype none

module svpwm_duty_checker import svpwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	// angle, d_voltage, q_voltage, amplitude
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// opcode
	input  logic [0:0]               s_axis_tuser,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// duty_u, duty_v, duty_w, sector
	input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	output int                       errors,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SECTOR_BITS-1:0] sector;
		logic [DUTY_BITS-1:0]   duty_w;
		logic [DUTY_BITS-1:0]   duty_v;
		logic [DUTY_BITS-1:0]   duty_u;
	} duty_set_t;

	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint ROOT3_Q30   = 64'sd1859775393;
	localparam longint ROOT3_HALF  = 64'sd929887697;
	localparam longint PI_SCALED   = 64'sd3373259426;
	localparam longint UNIT_L      = longint'(UNIT);

	// {beta > 0, steep, alpha > 0} -> sector, code 0 in the low bits
	localparam logic [7:0][2:0] SECTOR_BY_CODE =
		{3'd2, 3'd2, 3'd1, 3'd3, 3'd5, 3'd5, 3'd6, 3'd4};
	// high-side phases of active vector k+1, bit 0 = U, bit 2 = W
	localparam logic [5:0][2:0] VEC_PHASES =
		{3'b101, 3'b100, 3'b110, 3'b010, 3'b011, 3'b001};

	longint    quarter_sine [0:SINE_TABLE_ENTRIES];
	duty_set_t duty_expect_q [$];

	// errors and pending are 2-state and start at zero
	initial begin
		longint unsigned x;
		longint unsigned x_sq;
		longint unsigned term;
		longint          acc;
		for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
			x = (longint'(k) * PI_SCALED) / longint'(2 * SINE_TABLE_ENTRIES);
			x_sq = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
				acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > ONE_Q30)
				acc = ONE_Q30;
			quarter_sine[k] = acc;
		end
	end

	function automatic longint sine_at(input logic [ANGLE_BITS-1:0] phase);
		longint unsigned rem;
		longint unsigned idx;
		rem = phase & ((1 << QUARTER_BITS) - 1);
		idx = (rem * SINE_TABLE_ENTRIES) >> QUARTER_BITS;
		case (phase[ANGLE_BITS-1 -: 2])
			2'd0: return quarter_sine[idx];
			2'd1: return quarter_sine[SINE_TABLE_ENTRIES - idx];
			2'd2: return -quarter_sine[idx];
			default: return -quarter_sine[SINE_TABLE_ENTRIES - idx];
		endcase
	endfunction

	function automatic longint sixth_sin(input int k);
		case (k)
			1, 2: return ROOT3_HALF;
			4, 5: return -ROOT3_HALF;
			default: return 0;
		endcase
	endfunction

	function automatic longint sixth_cos(input int k);
		case (k)
			1, 5: return ONE_Q30 / 2;
			2, 4: return -ONE_Q30 / 2;
			3: return -ONE_Q30;
			default: return ONE_Q30;
		endcase
	endfunction

	function automatic duty_set_t svpwm_duties(input opcode_t op,
			input logic [ANGLE_BITS-1:0] ang, input logic signed [VALUE_BITS-1:0] v_d,
			input logic signed [VALUE_BITS-1:0] v_q,
			input logic signed [VALUE_BITS-1:0] amp);
		longint    sn, cs, x, y, alpha, beta, abs_a, abs_b, tm, tn, t0, duty;
		int        sec;
		logic [2:0] code;
		duty_set_t res;
		sn = sine_at(ang);
		cs = sine_at(ANGLE_BITS'(ang + (1 << QUARTER_BITS)));
		if (op == OP_DQ) begin
			x = longint'(v_d);
			y = longint'(v_q);
			alpha = (x * cs - y * sn) >>> 30;
			beta = (x * sn + y * cs) >>> 30;
			abs_a = (alpha < 0) ? -alpha : alpha;
			abs_b = (beta < 0) ? -beta : beta;
			code = {beta > 0, (abs_b << 30) > ROOT3_Q30 * abs_a, alpha > 0};
			sec = int'(SECTOR_BY_CODE[code]);
		end else begin
			x = longint'(amp);
			if (x < 0)
				x = 0;
			if (x > UNIT_L)
				x = UNIT_L;
			alpha = (x * cs) >>> 30;
			beta = (x * sn) >>> 30;
			sec = ((int'(ang) * 6) >> ANGLE_BITS) + 1;
			if (sec > 6)
				sec = 6;
		end
		tm = (alpha * sixth_sin(sec) - beta * sixth_cos(sec)) >>> 30;
		tn = (beta * sixth_cos(sec - 1) - alpha * sixth_sin(sec - 1)) >>> 30;
		// zero time uses the unfloored dwell times
		t0 = UNIT_L - tm - tn;
		if (tm < 0)
			tm = 0;
		if (tn < 0)
			tn = 0;
		if (t0 < 0)
			t0 = 0;
		for (int ph = 0; ph < 3; ph++) begin
			duty = t0 / 2;
			if (VEC_PHASES[sec - 1][ph])
				duty += tm;
			if (VEC_PHASES[sec % 6][ph])
				duty += tn;
			if (duty > UNIT_L)
				duty = UNIT_L;
			if (duty < 0)
				duty = 0;
			case (ph)
				0: res.duty_u = DUTY_BITS'(duty);
				1: res.duty_v = DUTY_BITS'(duty);
				default: res.duty_w = DUTY_BITS'(duty);
			endcase
		end
		res.sector = SECTOR_BITS'(sec);
		return res;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
				act_val);
		end
	endtask

	always @(posedge clk) begin
		duty_set_t exp_set;
		duty_set_t act_set;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				duty_expect_q.push_back(svpwm_duties(opcode_t'(s_axis_tuser[0]),
					s_axis_tdata[ANGLE_BITS-1:0],
					s_axis_tdata[ANGLE_BITS +: VALUE_BITS],
					s_axis_tdata[ANGLE_BITS + VALUE_BITS +: VALUE_BITS],
					s_axis_tdata[ANGLE_BITS + 2 * VALUE_BITS +: VALUE_BITS]));
			if (m_axis_tvalid && m_axis_tready) begin
				act_set = m_axis_tdata;
				if (duty_expect_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected output transfer, expected none, got %h",
						$time, m_axis_tdata);
				end else begin
					exp_set = duty_expect_q.pop_front();
					check_field("duty_u", exp_set.duty_u, act_set.duty_u);
					check_field("duty_v", exp_set.duty_v, act_set.duty_v);
					check_field("duty_w", exp_set.duty_w, act_set.duty_w);
					check_field("sector", exp_set.sector, act_set.sector);
				end
			end
			pending = duty_expect_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- sim/svpwm_duty_generator_tb.sv -----
// Top of the SVPWM duty generator testbench: clock, reset, stimulus, verdict.
// Depends on svpwm_pkg, svpwm_duty_generator and svpwm_duty_checker.
`default_nettype none

module svpwm_duty_generator_tb import svpwm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 650;

	logic                     clk;
	logic                     arst_n;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	// angle, d_voltage, q_voltage, amplitude
	logic [IN_DATA_BITS-1:0]  s_axis_tdata;
	// opcode
	logic [0:0]               s_axis_tuser;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	// duty_u, duty_v, duty_w, sector
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;

	int   errors;
	int   pending;
	logic in_xfer;
	logic out_xfer;
	logic burst;
	int   idle_cycles;

	svpwm_duty_generator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	svpwm_duty_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// transfer flags, read back at the following falling edge
	always @(posedge clk) begin
		in_xfer <= s_axis_tvalid && s_axis_tready;
		out_xfer <= m_axis_tvalid && m_axis_tready;
	end

	// idle_cycles is 2-state and starts at zero
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_xfer || out_xfer)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("svpwm_duty_generator_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic send_request(input opcode_t op, input logic [ANGLE_BITS-1:0] ang,
			input logic [VALUE_BITS-1:0] v_d, input logic [VALUE_BITS-1:0] v_q,
			input logic [VALUE_BITS-1:0] amp);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {amp, v_q, v_d, ang};
		s_axis_tuser <= op;
		do @(negedge clk); while (!in_xfer);
	endtask

	function automatic logic [VALUE_BITS-1:0] random_voltage();
		// mostly within the linear range, now and then anywhere
		if ($urandom_range(0, 3) == 0)
			return VALUE_BITS'($urandom);
		return VALUE_BITS'(int'($urandom_range(0, 20000)) - 10000);
	endfunction

	// receiver: random stall before each output transfer
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!out_xfer);
		end
	end

	initial begin
		opcode_t op;
		logic [VALUE_BITS-1:0] amp;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		burst = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// dq: zero vector, extremes, ignored amplitude
		send_request(OP_DQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DQ, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000);
		send_request(OP_DQ, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF);
		send_request(OP_DQ, 16'h4000, 16'h0000, 16'h7FFF, 16'h0000);
		send_request(OP_DQ, 16'h8000, 16'h2000, 16'hE000, 16'h8000);
		send_request(OP_DQ, 16'hC000, 16'hE000, 16'h1000, 16'h7FFF);
		send_request(OP_DQ, 16'd12345, 16'd4000, 16'd9000, 16'h5555);
		send_request(OP_DQ, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
		send_request(OP_DQ, 16'h2AAB, 16'h4000, 16'h0000, 16'h0000);
		send_request(OP_DQ, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_request(OP_DQ, 16'h1555, 16'h0001, 16'hFFFF, 16'h0000);
		// polar: sector edges, amplitude clamping, ignored d/q
		send_request(OP_POLAR, 16'h0000, 16'h7FFF, 16'h8000, 16'h4000);
		send_request(OP_POLAR, 16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF);
		send_request(OP_POLAR, 16'd10922, 16'h8000, 16'h7FFF, 16'd12000);
		send_request(OP_POLAR, 16'd10923, 16'h0000, 16'h0000, 16'd12000);
		send_request(OP_POLAR, 16'd21845, 16'hAAAA, 16'h5555, 16'd9000);
		send_request(OP_POLAR, 16'd21846, 16'h0000, 16'h0000, 16'd9000);
		send_request(OP_POLAR, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
		send_request(OP_POLAR, 16'd43690, 16'h0000, 16'h0000, 16'd8000);
		send_request(OP_POLAR, 16'd43691, 16'h0000, 16'h0000, 16'd8000);
		send_request(OP_POLAR, 16'd54613, 16'h0000, 16'h0000, 16'd16383);
		send_request(OP_POLAR, 16'd54614, 16'h0000, 16'h0000, 16'd16383);
		send_request(OP_POLAR, 16'h4000, 16'h0000, 16'h0000, 16'h0001);
		send_request(OP_POLAR, 16'hC000, 16'h0000, 16'h0000, 16'd16385);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			op = opcode_t'($urandom_range(0, 1));
			amp = ($urandom_range(0, 3) == 0) ? VALUE_BITS'($urandom)
				: VALUE_BITS'($urandom_range(0, UNIT));
			send_request(op, ANGLE_BITS'($urandom), random_voltage(), random_voltage(), amp);
		end
		s_axis_tvalid <= 1'b0;
		burst = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("svpwm_duty_generator_tb: done, clean");
		else
			$display("svpwm_duty_generator_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
